[design/fixed_point_q24_8_alu_macros.svh]
// Assertion macros for the fixed-point ALU checker.
// Included by fpa_chk.sv; expects i_clk and i_rst_n in scope.
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH

// Clocked property, muted while reset is held
`define FPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication that must hold on every clocked transaction
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
    `FPA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[design/fpa_pkg.sv]
// Package for the Q24.8 fixed-point ALU: word constants, operation codes,
// transaction structs. No dependencies.
`default_nettype none

package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_INT = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]                  req_type;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_raw;
        logic                        a_less;
        logic                        a_equal;
        logic                        a_greater;
        logic                        overflow;
        logic                        div_zero;
    } t_res;

    // Per-transaction control carried down the pipeline
    typedef struct packed {
        logic [3:0]           code;
        logic                 a_less;
        logic                 a_equal;
        logic                 a_greater;
        logic [WORD_BITS-1:0] simple;
        logic                 simple_ovf;
        logic                 neg;
        logic                 dz;
        logic [WORD_BITS-1:0] mul_val;
        logic                 mul_ovf;
    } t_ctl;

    // Saturation limit for a result of the given sign
    function automatic logic [WORD_BITS-1:0] sat_limit(input logic neg);
        return neg ? MIN_NEG : MAX_POS;
    endfunction

endpackage

`default_nettype wire

[design/fixed_point_q24_8_alu.sv]
// Q24.8 fixed-point ALU, top level. Uses fpa_pkg.
// Single pipeline shared by all operations; divider is one bit per stage.
//
// Accepts one transaction per clock while the output is not stalled. Each result
// passes the input register, operand prep, multiply/divide setup, 40 restoring-divide
// stages - one per quotient bit of the 40-bit scaled dividend - and the
// output register. Every operation takes the same path, so results leave
// in order. A stall on the output freezes the whole pipeline; o_stall is
// raised only while a finished result is held. Multiply and divide are exact
// and round half away from zero; out-of-range results saturate and set
// overflow. Divide by zero returns zero with div_zero set.
`default_nettype none

module fixed_point_q24_8_alu (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire fpa_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output fpa_pkg::t_res      o_res
);

    localparam int W  = fpa_pkg::WORD_BITS;
    localparam int F  = fpa_pkg::FRAC_BITS;
    localparam int NW = fpa_pkg::NUM_BITS;
    localparam int PW = fpa_pkg::PROD_BITS;
    localparam logic [PW:0] MUL_HALF = (PW+1)'(1) << (F-1);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 0: input register
    logic          r_v0;
    fpa_pkg::t_req r_in0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_in0 <= i_req;
        end
    end

    // Stage 1: compares, simple operations, magnitudes
    logic signed [W-1:0] a, b;
    logic signed [W:0]   sum, dif;
    logic [W-1:0]        ma, mb;
    fpa_pkg::t_ctl       n_c1;

    assign a   = r_in0.operand_a;
    assign b   = r_in0.operand_b;
    assign sum = {a[W-1], a} + {b[W-1], b};
    assign dif = {a[W-1], a} - {b[W-1], b};
    assign ma  = a[W-1] ? (~a + W'(1)) : a;
    assign mb  = b[W-1] ? (~b + W'(1)) : b;

    always_comb begin
        n_c1            = '0;
        n_c1.code       = r_in0.req_type;
        n_c1.a_less     = (a < b);
        n_c1.a_equal    = (a == b);
        n_c1.a_greater  = (a > b);
        n_c1.neg        = a[W-1] ^ b[W-1];
        n_c1.dz         = (b == '0);
        case (fpa_pkg::t_op'(r_in0.req_type))
            fpa_pkg::OP_ADD: begin
                n_c1.simple_ovf = sum[W] != sum[W-1];
                n_c1.simple     = n_c1.simple_ovf ? fpa_pkg::sat_limit(a[W-1]) : sum[W-1:0];
            end
            fpa_pkg::OP_SUB: begin
                n_c1.simple_ovf = dif[W] != dif[W-1];
                n_c1.simple     = n_c1.simple_ovf ? fpa_pkg::sat_limit(a[W-1]) : dif[W-1:0];
            end
            fpa_pkg::OP_MIN: n_c1.simple = (a <= b) ? a : b;
            fpa_pkg::OP_MAX: n_c1.simple = (a <= b) ? b : a;
            fpa_pkg::OP_INC: begin
                n_c1.simple_ovf = (a == fpa_pkg::MAX_POS);
                n_c1.simple     = n_c1.simple_ovf ? a : a + W'(1);
            end
            fpa_pkg::OP_DEC: begin
                n_c1.simple_ovf = (a == fpa_pkg::MIN_NEG);
                n_c1.simple     = n_c1.simple_ovf ? a : a - W'(1);
            end
            fpa_pkg::OP_INT: n_c1.simple = a >>> F;
            default:         n_c1.simple = '0;
        endcase
    end

    logic          r_v1;
    fpa_pkg::t_ctl r_c1;
    logic [W-1:0]  r_ma1, r_mb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r_c1  <= n_c1;
            r_ma1 <= ma;
            r_mb1 <= mb;
        end
    end

    // Divider stage array; index 0 is setup, each later index one quotient bit
    logic          r_vd  [0:NW];
    fpa_pkg::t_ctl r_cd  [0:NW];
    logic [W-1:0]  r_rem [0:NW];
    logic [W-1:0]  r_den [0:NW];
    logic [NW-1:0] r_num [0:NW];
    logic [NW-1:0] r_quo [0:NW];
    logic [PW-1:0] r_prod;

    // Setup: full-width product and divider seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v1;
        end
        if (en) begin
            r_cd[0]  <= r_c1;
            r_prod   <= r_ma1 * r_mb1;
            r_rem[0] <= '0;
            r_den[0] <= r_mb1;
            r_num[0] <= {r_ma1, F'(0)};
            r_quo[0] <= '0;
        end
    end

    // Multiply rounding and saturation, folded into the first divide stage
    logic [PW:0]   prod_rnd, prod_sh;
    fpa_pkg::t_ctl c_mul;

    assign prod_rnd = {1'b0, r_prod} + MUL_HALF;
    assign prod_sh  = prod_rnd >> F;

    always_comb begin
        c_mul         = r_cd[0];
        c_mul.mul_ovf = prod_sh > (PW+1)'(fpa_pkg::sat_limit(r_cd[0].neg));
        if (c_mul.mul_ovf) begin
            c_mul.mul_val = fpa_pkg::sat_limit(r_cd[0].neg);
        end else if (r_cd[0].neg) begin
            c_mul.mul_val = ~prod_sh[W-1:0] + W'(1);
        end else begin
            c_mul.mul_val = prod_sh[W-1:0];
        end
    end

    for (genvar k = 1; k <= NW; k++) begin : g_div
        logic [W:0] sh, dsub;
        logic       ge;

        // Restoring step: shift in next dividend bit, trial subtract
        assign sh   = {r_rem[k-1], r_num[k-1][NW-1]};
        assign dsub = sh - {1'b0, r_den[k-1]};
        assign ge   = sh >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else if (en) begin
                r_vd[k] <= r_vd[k-1];
            end
            if (en) begin
                r_cd[k]  <= (k == 1) ? c_mul : r_cd[k-1];
                r_rem[k] <= ge ? dsub[W-1:0] : sh[W-1:0];
                r_den[k] <= r_den[k-1];
                r_num[k] <= r_num[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][NW-2:0], ge};
            end
        end
    end

    // Final: divide rounding, saturation and result select
    fpa_pkg::t_ctl c_f;
    logic          rnd;
    logic [NW:0]   q_rnd;
    logic          div_ovf;
    logic [W-1:0]  div_val;
    fpa_pkg::t_res n_res;

    assign c_f     = r_cd[NW];
    assign rnd     = {r_rem[NW], 1'b0} >= {1'b0, r_den[NW]};
    assign q_rnd   = {1'b0, r_quo[NW]} + (NW+1)'(rnd);
    assign div_ovf = q_rnd > (NW+1)'(fpa_pkg::sat_limit(c_f.neg));

    always_comb begin
        if (div_ovf) begin
            div_val = fpa_pkg::sat_limit(c_f.neg);
        end else if (c_f.neg) begin
            div_val = ~q_rnd[W-1:0] + W'(1);
        end else begin
            div_val = q_rnd[W-1:0];
        end

        n_res           = '0;
        n_res.a_less    = c_f.a_less;
        n_res.a_equal   = c_f.a_equal;
        n_res.a_greater = c_f.a_greater;
        case (fpa_pkg::t_op'(c_f.code))
            fpa_pkg::OP_MUL: begin
                n_res.result_raw = c_f.mul_val;
                n_res.overflow   = c_f.mul_ovf;
            end
            fpa_pkg::OP_DIV: begin
                n_res.div_zero   = c_f.dz;
                n_res.result_raw = c_f.dz ? '0 : div_val;
                n_res.overflow   = !c_f.dz && div_ovf;
            end
            default: begin
                n_res.result_raw = c_f.simple;
                n_res.overflow   = c_f.simple_ovf;
            end
        endcase
    end

    // Output register
    logic          r_vo;
    fpa_pkg::t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vd[NW];
        end
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_vo;
    assign o_res   = r_res;

endmodule

`default_nettype wire

[design/fpa_chk.sv]
// Port-level checker for the fixed-point ALU, with its bind.
// Uses fpa_pkg and fixed_point_q24_8_alu_macros.svh.
`default_nettype none

`include "fixed_point_q24_8_alu_macros.svh"

module fpa_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_stall,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire fpa_pkg::t_res i_out
);

    // Held result stays put until taken
    `FPA_ASSERT_IMP(a_out_hold, i_out_valid && i_out_stall, ##1 (i_out_valid && $stable(i_out)), "output transaction changed under stall")

    // Upstream is held back only by a waiting result
    `FPA_ASSERT_IMP(a_in_stall_src, i_in_stall, i_out_valid && i_out_stall, "input stalled without a held result")

    // Exactly one compare flag per result
    `FPA_ASSERT_IMP(a_cmp_onehot, i_out_valid, $onehot({i_out.a_less, i_out.a_equal, i_out.a_greater}), "compare flags not one-hot")

    // Divide by zero gives zero and no overflow
    `FPA_ASSERT_IMP(a_dz_zero, i_out_valid && i_out.div_zero, (i_out.result_raw == '0) && !i_out.overflow, "divide by zero result not clean")

endmodule

bind fixed_point_q24_8_alu fpa_chk u_fpa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out       (o_res)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for the Q24.8 fixed-point ALU: directed table, then random traffic,
// checked against typed-in results or an exact arithmetic predictor. Depends on fpa_pkg.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM  = 500;
    localparam int  PIPE_LAT  = 44;
    localparam int  CYCLE_CAP = 200000;

    localparam int              WORD_BITS = fpa_pkg::WORD_BITS;
    localparam int              FRAC_BITS = fpa_pkg::FRAC_BITS;
    localparam logic [31:0]     MAX_POS   = fpa_pkg::MAX_POS;
    localparam logic [31:0]     MIN_NEG   = fpa_pkg::MIN_NEG;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    fpa_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    fpa_pkg::t_res o_res;

    int            cycles;
    int            n_errors;
    bit            stim_done;
    bit            hold_off_req;
    fpa_pkg::t_res expected_q[$];

    fixed_point_q24_8_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Saturate a wide signed value to the word range
    function automatic logic [WORD_BITS-1:0] clamp(input logic signed [127:0] v,
                                                   output bit ovf);
        ovf = 1'b0;
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return MAX_POS;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return MIN_NEG;
        end
        return v[WORD_BITS-1:0];
    endfunction

    // Exact ALU result for one transaction
    function automatic fpa_pkg::t_res alu_result(input fpa_pkg::t_req rq);
        fpa_pkg::t_res r;
        logic signed [127:0] a, b, num, mag, den, q, rem;
        bit neg, ovf;
        a = rq.operand_a;
        b = rq.operand_b;
        r = '0;
        ovf = 1'b0;
        r.a_less    = a < b;
        r.a_equal   = a == b;
        r.a_greater = a > b;
        case (rq.req_type)
            fpa_pkg::OP_ADD: r.result_raw = clamp(a + b, ovf);
            fpa_pkg::OP_SUB: r.result_raw = clamp(a - b, ovf);
            fpa_pkg::OP_INC: r.result_raw = clamp(a + 1, ovf);
            fpa_pkg::OP_DEC: r.result_raw = clamp(a - 1, ovf);
            fpa_pkg::OP_MIN: r.result_raw = (a <= b) ? a[31:0] : b[31:0];
            fpa_pkg::OP_MAX: r.result_raw = (a <= b) ? b[31:0] : a[31:0];
            fpa_pkg::OP_INT: r.result_raw = rq.operand_a >>> FRAC_BITS;
            fpa_pkg::OP_MUL: begin
                neg = (a < 0) != (b < 0);
                mag = (a < 0 ? -a : a) * (b < 0 ? -b : b);
                mag = (mag + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                r.result_raw = clamp(neg ? -mag : mag, ovf);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    neg = (a < 0) != (b < 0);
                    num = (a < 0 ? -a : a) <<< FRAC_BITS;
                    den = b < 0 ? -b : b;
                    q   = num / den;
                    rem = num % den;
                    // half away from zero
                    if (2 * rem >= den)
                        q = q + 1;
                    r.result_raw = clamp(neg ? -q : q, ovf);
                end
            end
            default: r.result_raw = '0;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    // Directed table; has_exp marks rows whose result is typed in
    typedef struct {
        fpa_pkg::t_req req;
        bit            has_exp;
        fpa_pkg::t_res exp_res;
    } t_row;

    t_row directed[$];

    function automatic fpa_pkg::t_req mk(input logic [3:0] op, input logic [31:0] a,
                                         input logic [31:0] b);
        fpa_pkg::t_req q;
        q.req_type  = op;
        q.operand_a = a;
        q.operand_b = b;
        return q;
    endfunction

    function automatic fpa_pkg::t_res mkres(input logic [31:0] v, input bit lt,
                                            input bit eq, input bit gt, input bit ov,
                                            input bit dz);
        fpa_pkg::t_res r;
        r.result_raw = v;
        r.a_less     = lt;
        r.a_equal    = eq;
        r.a_greater  = gt;
        r.overflow   = ov;
        r.div_zero   = dz;
        return r;
    endfunction

    task automatic add_row(input fpa_pkg::t_req rq, input bit he, input fpa_pkg::t_res er);
        t_row w;
        w.req = rq;
        w.has_exp = he;
        w.exp_res = er;
        directed.push_back(w);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return MAX_POS - $urandom_range(0, 3);
            1: return MIN_NEG + $urandom_range(0, 3);
            2: return $urandom_range(0, 2047) - 1024;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Valid drops only across an idle gap, so back-to-back items keep it high
    task automatic send(input fpa_pkg::t_req rq);
        int gap;
        gap = $urandom_range(0, 9);
        if (hold_off_req)
            gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Sender
    initial begin
        fpa_pkg::t_req rq;
        i_valid   = 1'b0;
        i_req     = '0;
        i_rst_n   = 1'b0;
        stim_done = 1'b0;
        hold_off_req = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(fpa_pkg::OP_ADD, MAX_POS, 32'd1), 1, mkres(MAX_POS, 0, 0, 1, 1, 0));
        add_row(mk(fpa_pkg::OP_ADD, MIN_NEG, MIN_NEG), 1, mkres(MIN_NEG, 0, 1, 0, 1, 0));
        add_row(mk(fpa_pkg::OP_SUB, MIN_NEG, 32'd1), 1, mkres(MIN_NEG, 1, 0, 0, 1, 0));
        add_row(mk(fpa_pkg::OP_SUB, MAX_POS, MIN_NEG), 1, mkres(MAX_POS, 0, 0, 1, 1, 0));
        add_row(mk(fpa_pkg::OP_MUL, 32'h180, 32'h80), 1, mkres(32'hC0, 0, 0, 1, 0, 0));
        add_row(mk(fpa_pkg::OP_MUL, 32'h1, 32'h80), 0, '0);
        add_row(mk(fpa_pkg::OP_MUL, -32'sd1, 32'h80), 0, '0);
        add_row(mk(fpa_pkg::OP_MUL, MAX_POS, MAX_POS), 1, mkres(MAX_POS, 0, 1, 0, 1, 0));
        add_row(mk(fpa_pkg::OP_MUL, MIN_NEG, MAX_POS), 0, '0);
        add_row(mk(fpa_pkg::OP_DIV, 32'h300, 32'd0), 1, mkres(32'd0, 0, 0, 1, 0, 1));
        add_row(mk(fpa_pkg::OP_DIV, MIN_NEG, -32'sd1), 1, mkres(MAX_POS, 1, 0, 0, 1, 0));
        add_row(mk(fpa_pkg::OP_DIV, 32'h100, 32'h300), 0, '0);
        add_row(mk(fpa_pkg::OP_DIV, 32'h1, 32'h200), 0, '0);
        add_row(mk(fpa_pkg::OP_DIV, -32'sd1, 32'h200), 0, '0);
        add_row(mk(fpa_pkg::OP_DIV, MAX_POS, MIN_NEG), 0, '0);
        add_row(mk(fpa_pkg::OP_MIN, MIN_NEG, MAX_POS), 1, mkres(MIN_NEG, 1, 0, 0, 0, 0));
        add_row(mk(fpa_pkg::OP_MAX, MIN_NEG, MAX_POS), 1, mkres(MAX_POS, 1, 0, 0, 0, 0));
        add_row(mk(fpa_pkg::OP_INC, MAX_POS, 32'd0), 1, mkres(MAX_POS, 0, 0, 1, 1, 0));
        add_row(mk(fpa_pkg::OP_DEC, MIN_NEG, 32'd0), 1, mkres(MIN_NEG, 1, 0, 0, 1, 0));
        add_row(mk(fpa_pkg::OP_INT, -32'sd1, 32'd0), 1,
                mkres(32'hFFFFFFFF, 1, 0, 0, 0, 0));
        add_row(mk(fpa_pkg::OP_INT, MAX_POS, MAX_POS), 1,
                mkres(32'h007FFFFF, 0, 1, 0, 0, 0));
        add_row(mk(4'd9, 32'd5, 32'd7), 1, mkres(32'd0, 1, 0, 0, 0, 0));
        add_row(mk(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF), 1, mkres(32'd0, 0, 1, 0, 0, 0));

        foreach (directed[k]) begin
            expected_q.push_back(directed[k].has_exp ? directed[k].exp_res
                                                     : alu_result(directed[k].req));
            send(directed[k].req);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            rq.req_type  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8));
            rq.operand_a = rand_operand();
            rq.operand_b = ($urandom_range(0, 15) == 0) ? 32'd0
                         : ($urandom_range(0, 15) == 0) ? rq.operand_a : rand_operand();
            // back-to-back burst while the receiver holds off
            hold_off_req = (n >= 200 && n < 300);
            expected_q.push_back(alu_result(rq));
            send(rq);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall, with long hold-offs while the mid-run burst is sent
    initial begin
        int wait_cyc;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (150) @(posedge i_clk);
            end
            wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (wait_cyc > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cyc) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        fpa_pkg::t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected transaction: result_raw %h", o_res.result_raw);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_res.result_raw !== e.result_raw) begin
                    $error("result_raw exp %h got %h", e.result_raw, o_res.result_raw);
                    n_errors++;
                end
                if (o_res.a_less !== e.a_less) begin
                    $error("a_less exp %b got %b", e.a_less, o_res.a_less);
                    n_errors++;
                end
                if (o_res.a_equal !== e.a_equal) begin
                    $error("a_equal exp %b got %b", e.a_equal, o_res.a_equal);
                    n_errors++;
                end
                if (o_res.a_greater !== e.a_greater) begin
                    $error("a_greater exp %b got %b", e.a_greater, o_res.a_greater);
                    n_errors++;
                end
                if (o_res.overflow !== e.overflow) begin
                    $error("overflow exp %b got %b", e.overflow, o_res.overflow);
                    n_errors++;
                end
                if (o_res.div_zero !== e.div_zero) begin
                    $error("div_zero exp %b got %b", e.div_zero, o_res.div_zero);
                    n_errors++;
                end
            end
        end
    end

    // End of run and watchdog
    initial begin
        n_errors = 0;
        cycles   = 0;
        while (!(stim_done && expected_q.size() == 0) && cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_CAP) begin
            $display("TEST FAILED");
        end else begin
            repeat (PIPE_LAT + 10) @(posedge i_clk);
            if (n_errors == 0 && expected_q.size() == 0) begin
                $display("TEST PASSED");
            end else begin
                $display("TEST FAILED");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire

[fixed_point_q24_8_alu.f]
+incdir+design
design/fpa_pkg.sv
design/fixed_point_q24_8_alu.sv
design/fpa_chk.sv
tb/sv/testbench.sv
